FILE: hdl/kf2_pkg.sv
package kf2_pkg;

  localparam int DATA_W = 32;
  localparam int SEL_W  = 7;
  localparam int TMP_AW = 6;
  localparam int TMP_DEPTH = 64;
  localparam int PC_W   = 7;
  localparam int PROG_LEN = 108;
  localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROG_LEN - 1);

  // Configuration register indexes
  localparam logic [3:0] REG_Q00 = 4'd0;
  localparam logic [3:0] REG_Q01 = 4'd1;
  localparam logic [3:0] REG_Q10 = 4'd2;
  localparam logic [3:0] REG_Q11 = 4'd3;
  localparam logic [3:0] REG_R00 = 4'd4;
  localparam logic [3:0] REG_R01 = 4'd5;
  localparam logic [3:0] REG_R10 = 4'd6;
  localparam logic [3:0] REG_R11 = 4'd7;

  localparam logic [DATA_W-1:0] Q_DIAG_RST = 32'd65;
  localparam logic [DATA_W-1:0] R_DIAG_RST = 32'd65536;

  // Operand / destination select codes; bit 6 set selects a scratch RAM entry
  localparam logic [SEL_W-1:0] SRC_Q00  = 7'd0;
  localparam logic [SEL_W-1:0] SRC_Q01  = 7'd1;
  localparam logic [SEL_W-1:0] SRC_Q10  = 7'd2;
  localparam logic [SEL_W-1:0] SRC_Q11  = 7'd3;
  localparam logic [SEL_W-1:0] SRC_R00  = 7'd4;
  localparam logic [SEL_W-1:0] SRC_R01  = 7'd5;
  localparam logic [SEL_W-1:0] SRC_R10  = 7'd6;
  localparam logic [SEL_W-1:0] SRC_R11  = 7'd7;
  localparam logic [SEL_W-1:0] SRC_EST0 = 7'd8;
  localparam logic [SEL_W-1:0] SRC_EST1 = 7'd9;
  localparam logic [SEL_W-1:0] SRC_COV0 = 7'd10;
  localparam logic [SEL_W-1:0] SRC_COV1 = 7'd11;
  localparam logic [SEL_W-1:0] SRC_COV2 = 7'd12;
  localparam logic [SEL_W-1:0] SRC_COV3 = 7'd13;
  localparam logic [SEL_W-1:0] SRC_Z0   = 7'd14;
  localparam logic [SEL_W-1:0] SRC_Z1   = 7'd15;
  localparam logic [SEL_W-1:0] SRC_DT   = 7'd16;
  localparam logic [SEL_W-1:0] SRC_ONE  = 7'd17;
  localparam logic [SEL_W-1:0] SRC_ZERO = 7'd18;
  localparam logic [SEL_W-1:0] SRC_XP0  = 7'd19;
  localparam logic [SEL_W-1:0] SRC_XP1  = 7'd20;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_MULW, ST_DIVW, ST_DONE
  } seq_state_t;

  typedef struct packed {
    alu_op_t    op;
    logic       mul_load;
  } alu_ctl_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SEL_W-1:0] dst;
    logic [SEL_W-1:0] sa;
    logic [SEL_W-1:0] sb;
    logic             skip_sing;  // write zero when the innovation is singular
    logic             set_sing;   // result is the determinant
  } uop_t;

  function automatic logic [SEL_W-1:0] tmp(input int n);
    return {1'b1, TMP_AW'(n)};
  endfunction

  function automatic uop_t mk(input alu_op_t op, input logic [SEL_W-1:0] d,
                              input logic [SEL_W-1:0] a, input logic [SEL_W-1:0] b);
    uop_t u;
    u.op = op;
    u.dst = d;
    u.sa = a;
    u.sb = b;
    u.skip_sing = 1'b0;
    u.set_sing = 1'b0;
    return u;
  endfunction

  function automatic uop_t mk_skip(input alu_op_t op, input logic [SEL_W-1:0] d,
                                   input logic [SEL_W-1:0] a, input logic [SEL_W-1:0] b);
    uop_t u;
    u = mk(op, d, a, b);
    u.skip_sing = 1'b1;
    return u;
  endfunction

  // Micro-program for one filter step
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    u = mk(OP_ADD, tmp(63), SRC_ZERO, SRC_ZERO);
    case (pc)
      // predicted covariance A P A^T + Q
      7'd0:   u = mk(OP_MUL, tmp(0), SRC_DT, SRC_COV2);
      7'd1:   u = mk(OP_ADD, tmp(1), SRC_COV0, tmp(0));
      7'd2:   u = mk(OP_MUL, tmp(2), SRC_DT, SRC_COV3);
      7'd3:   u = mk(OP_ADD, tmp(3), SRC_COV1, tmp(2));
      7'd4:   u = mk(OP_MUL, tmp(4), tmp(3), SRC_DT);
      7'd5:   u = mk(OP_ADD, tmp(5), tmp(1), tmp(4));
      7'd6:   u = mk(OP_MUL, tmp(6), SRC_COV3, SRC_DT);
      7'd7:   u = mk(OP_ADD, tmp(7), SRC_COV2, tmp(6));
      7'd8:   u = mk(OP_ADD, tmp(8), tmp(5), SRC_Q00);
      7'd9:   u = mk(OP_ADD, tmp(9), tmp(3), SRC_Q01);
      7'd10:  u = mk(OP_ADD, tmp(10), tmp(7), SRC_Q10);
      7'd11:  u = mk(OP_ADD, tmp(11), SRC_COV3, SRC_Q11);
      // predicted state
      7'd12:  u = mk(OP_MUL, tmp(12), SRC_DT, SRC_EST1);
      7'd13:  u = mk(OP_ADD, SRC_XP0, SRC_EST0, tmp(12));
      7'd14:  u = mk(OP_ADD, SRC_XP1, SRC_EST1, SRC_ZERO);
      // innovation covariance and determinant
      7'd15:  u = mk(OP_ADD, tmp(14), tmp(8), SRC_R00);
      7'd16:  u = mk(OP_ADD, tmp(15), tmp(9), SRC_R01);
      7'd17:  u = mk(OP_ADD, tmp(16), tmp(10), SRC_R10);
      7'd18:  u = mk(OP_ADD, tmp(17), tmp(11), SRC_R11);
      7'd19:  u = mk(OP_MUL, tmp(18), tmp(14), tmp(17));
      7'd20:  u = mk(OP_MUL, tmp(19), tmp(15), tmp(16));
      7'd21:  begin
        u = mk(OP_SUB, tmp(20), tmp(18), tmp(19));
        u.set_sing = 1'b1;
      end
      // adjugate and inverse
      7'd22:  u = mk_skip(OP_SUB, tmp(21), SRC_ZERO, tmp(15));
      7'd23:  u = mk_skip(OP_SUB, tmp(22), SRC_ZERO, tmp(16));
      7'd24:  u = mk_skip(OP_DIV, tmp(23), tmp(17), tmp(20));
      7'd25:  u = mk_skip(OP_DIV, tmp(24), tmp(21), tmp(20));
      7'd26:  u = mk_skip(OP_DIV, tmp(25), tmp(22), tmp(20));
      7'd27:  u = mk_skip(OP_DIV, tmp(26), tmp(14), tmp(20));
      // gain K = P_prior * inv(S)
      7'd28:  u = mk(OP_MUL, tmp(60), tmp(8), tmp(23));
      7'd29:  u = mk(OP_MUL, tmp(61), tmp(9), tmp(25));
      7'd30:  u = mk(OP_ADD, tmp(27), tmp(60), tmp(61));
      7'd31:  u = mk(OP_MUL, tmp(60), tmp(8), tmp(24));
      7'd32:  u = mk(OP_MUL, tmp(61), tmp(9), tmp(26));
      7'd33:  u = mk(OP_ADD, tmp(28), tmp(60), tmp(61));
      7'd34:  u = mk(OP_MUL, tmp(60), tmp(10), tmp(23));
      7'd35:  u = mk(OP_MUL, tmp(61), tmp(11), tmp(25));
      7'd36:  u = mk(OP_ADD, tmp(29), tmp(60), tmp(61));
      7'd37:  u = mk(OP_MUL, tmp(60), tmp(10), tmp(24));
      7'd38:  u = mk(OP_MUL, tmp(61), tmp(11), tmp(26));
      7'd39:  u = mk(OP_ADD, tmp(30), tmp(60), tmp(61));
      // residual and state update
      7'd40:  u = mk(OP_SUB, tmp(39), SRC_Z0, SRC_XP0);
      7'd41:  u = mk(OP_SUB, tmp(40), SRC_Z1, SRC_XP1);
      7'd42:  u = mk(OP_MUL, tmp(60), tmp(27), tmp(39));
      7'd43:  u = mk(OP_MUL, tmp(61), tmp(28), tmp(40));
      7'd44:  u = mk(OP_ADD, tmp(43), tmp(60), tmp(61));
      7'd45:  u = mk(OP_ADD, tmp(44), SRC_XP0, tmp(43));
      7'd46:  u = mk(OP_MUL, tmp(60), tmp(29), tmp(39));
      7'd47:  u = mk(OP_MUL, tmp(61), tmp(30), tmp(40));
      7'd48:  u = mk(OP_ADD, tmp(47), tmp(60), tmp(61));
      7'd49:  u = mk(OP_ADD, tmp(48), SRC_XP1, tmp(47));
      // M = I - K
      7'd50:  u = mk(OP_SUB, tmp(49), SRC_ONE, tmp(27));
      7'd51:  u = mk(OP_SUB, tmp(50), SRC_ZERO, tmp(28));
      7'd52:  u = mk(OP_SUB, tmp(51), SRC_ZERO, tmp(29));
      7'd53:  u = mk(OP_SUB, tmp(52), SRC_ONE, tmp(30));
      // M * P_prior
      7'd54:  u = mk(OP_MUL, tmp(60), tmp(49), tmp(8));
      7'd55:  u = mk(OP_MUL, tmp(61), tmp(50), tmp(10));
      7'd56:  u = mk(OP_ADD, tmp(53), tmp(60), tmp(61));
      7'd57:  u = mk(OP_MUL, tmp(60), tmp(49), tmp(9));
      7'd58:  u = mk(OP_MUL, tmp(61), tmp(50), tmp(11));
      7'd59:  u = mk(OP_ADD, tmp(54), tmp(60), tmp(61));
      7'd60:  u = mk(OP_MUL, tmp(60), tmp(51), tmp(8));
      7'd61:  u = mk(OP_MUL, tmp(61), tmp(52), tmp(10));
      7'd62:  u = mk(OP_ADD, tmp(55), tmp(60), tmp(61));
      7'd63:  u = mk(OP_MUL, tmp(60), tmp(51), tmp(9));
      7'd64:  u = mk(OP_MUL, tmp(61), tmp(52), tmp(11));
      7'd65:  u = mk(OP_ADD, tmp(56), tmp(60), tmp(61));
      // (M P) M^T
      7'd66:  u = mk(OP_MUL, tmp(60), tmp(53), tmp(49));
      7'd67:  u = mk(OP_MUL, tmp(61), tmp(54), tmp(50));
      7'd68:  u = mk(OP_ADD, tmp(0), tmp(60), tmp(61));
      7'd69:  u = mk(OP_MUL, tmp(60), tmp(53), tmp(51));
      7'd70:  u = mk(OP_MUL, tmp(61), tmp(54), tmp(52));
      7'd71:  u = mk(OP_ADD, tmp(1), tmp(60), tmp(61));
      7'd72:  u = mk(OP_MUL, tmp(60), tmp(55), tmp(49));
      7'd73:  u = mk(OP_MUL, tmp(61), tmp(56), tmp(50));
      7'd74:  u = mk(OP_ADD, tmp(2), tmp(60), tmp(61));
      7'd75:  u = mk(OP_MUL, tmp(60), tmp(55), tmp(51));
      7'd76:  u = mk(OP_MUL, tmp(61), tmp(56), tmp(52));
      7'd77:  u = mk(OP_ADD, tmp(3), tmp(60), tmp(61));
      // K * R
      7'd78:  u = mk(OP_MUL, tmp(60), tmp(27), SRC_R00);
      7'd79:  u = mk(OP_MUL, tmp(61), tmp(28), SRC_R10);
      7'd80:  u = mk(OP_ADD, tmp(4), tmp(60), tmp(61));
      7'd81:  u = mk(OP_MUL, tmp(60), tmp(27), SRC_R01);
      7'd82:  u = mk(OP_MUL, tmp(61), tmp(28), SRC_R11);
      7'd83:  u = mk(OP_ADD, tmp(5), tmp(60), tmp(61));
      7'd84:  u = mk(OP_MUL, tmp(60), tmp(29), SRC_R00);
      7'd85:  u = mk(OP_MUL, tmp(61), tmp(30), SRC_R10);
      7'd86:  u = mk(OP_ADD, tmp(6), tmp(60), tmp(61));
      7'd87:  u = mk(OP_MUL, tmp(60), tmp(29), SRC_R01);
      7'd88:  u = mk(OP_MUL, tmp(61), tmp(30), SRC_R11);
      7'd89:  u = mk(OP_ADD, tmp(7), tmp(60), tmp(61));
      // (K R) K^T
      7'd90:  u = mk(OP_MUL, tmp(60), tmp(4), tmp(27));
      7'd91:  u = mk(OP_MUL, tmp(61), tmp(5), tmp(28));
      7'd92:  u = mk(OP_ADD, tmp(12), tmp(60), tmp(61));
      7'd93:  u = mk(OP_MUL, tmp(60), tmp(4), tmp(29));
      7'd94:  u = mk(OP_MUL, tmp(61), tmp(5), tmp(30));
      7'd95:  u = mk(OP_ADD, tmp(13), tmp(60), tmp(61));
      7'd96:  u = mk(OP_MUL, tmp(60), tmp(6), tmp(27));
      7'd97:  u = mk(OP_MUL, tmp(61), tmp(7), tmp(28));
      7'd98:  u = mk(OP_ADD, tmp(14), tmp(60), tmp(61));
      7'd99:  u = mk(OP_MUL, tmp(60), tmp(6), tmp(29));
      7'd100: u = mk(OP_MUL, tmp(61), tmp(7), tmp(30));
      7'd101: u = mk(OP_ADD, tmp(15), tmp(60), tmp(61));
      // commit state
      7'd102: u = mk(OP_ADD, SRC_COV0, tmp(0), tmp(12));
      7'd103: u = mk(OP_ADD, SRC_COV1, tmp(1), tmp(13));
      7'd104: u = mk(OP_ADD, SRC_COV2, tmp(2), tmp(14));
      7'd105: u = mk(OP_ADD, SRC_COV3, tmp(3), tmp(15));
      7'd106: u = mk(OP_ADD, SRC_EST0, tmp(44), SRC_ZERO);
      7'd107: u = mk(OP_ADD, SRC_EST1, tmp(48), SRC_ZERO);
      default: u = mk(OP_ADD, tmp(63), SRC_ZERO, SRC_ZERO);
    endcase
    return u;
  endfunction

endpackage

FILE: hdl/kf2_ram.sv
module kf2_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hdl/kf2_div.sv
module kf2_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] d,
  output logic        done,
  output logic [31:0] q,
  output logic        sat
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [31:0]   rem_r;
  logic [31:0]   dmag_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [31:0] amag, dmag;
  logic [32:0] rem_sh, rem_diff;
  logic        ge;
  logic        big;
  logic [31:0] qlow;

  assign amag = a[31] ? (32'd0 - a) : a;
  assign dmag = d[31] ? (32'd0 - d) : d;

  // One quotient bit per cycle, restoring
  assign rem_sh   = {rem_r, num_r[NW-1]};
  assign ge       = rem_sh >= {1'b0, dmag_r};
  assign rem_diff = rem_sh - {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= {amag, {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      dmag_r <= dmag;
      neg_r  <= a[31] ^ d[31];
    end else if (busy_r) begin
      rem_r <= ge ? rem_diff[31:0] : rem_sh[31:0];
      num_r <= {num_r[NW-2:0], ge};
    end
  end

  // Apply sign and saturate
  assign big  = |num_r[NW-1:32];
  assign qlow = num_r[31:0];

  always_comb begin
    if (neg_r) begin
      sat = big | (qlow[31] & (|qlow[30:0]));
      q   = sat ? 32'h8000_0000 : (32'd0 - qlow);
    end else begin
      sat = big | qlow[31];
      q   = sat ? 32'h7fff_ffff : qlow;
    end
  end

  assign done = done_r;

endmodule

FILE: hdl/kf2_alu.sv
module kf2_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  kf2_pkg::alu_ctl_t ctl,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       res,
  output logic              sat
);

  import kf2_pkg::*;

  logic signed [63:0] prod_r;
  logic signed [63:0] shifted;
  logic [32:0]        sum;
  logic               sum_sat, mul_sat;
  logic [31:0]        sum_res, mul_res;

  // Register the full product
  always_ff @(posedge clk) begin
    if (ctl.mul_load) begin
      prod_r <= $signed(a) * $signed(b);
    end
  end

  // Floor shift and saturate the product
  assign shifted = prod_r >>> FRAC_BITS;
  assign mul_sat = !((&shifted[63:31]) || !(|shifted[63:31]));
  assign mul_res = mul_sat ? (shifted[63] ? 32'h8000_0000 : 32'h7fff_ffff)
                           : shifted[31:0];

  // Saturating add and subtract
  assign sum = (ctl.op == OP_SUB) ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
  assign sum_sat = sum[32] ^ sum[31];
  assign sum_res = sum_sat ? (sum[32] ? 32'h8000_0000 : 32'h7fff_ffff) : sum[31:0];

  always_comb begin
    case (ctl.op)
      OP_MUL: begin
        res = mul_res;
        sat = mul_sat;
      end
      default: begin
        res = sum_res;
        sat = sum_sat;
      end
    endcase
  end

endmodule

FILE: hdl/kalman_filter_two_state.sv
// Two-state (angle, rate) Kalman filter in signed fixed point with FRAC_BITS
// fraction bits. Each accepted item (measured angle, measured rate, time step)
// runs one predict/update step through a 108-step micro-program on a single
// shared multiply/add unit plus a one-bit-per-cycle divider, with scratch
// values in a 64-entry RAM. Each micro-op passes through fetch and execute; a
// multiply adds a wait state for the product and each of the four divides waits
// in a divide state until the divider is done. A step is shorter when the
// innovation matrix is singular since the divides are then skipped; the input is
// not ready while a step runs. The result is held in an output register, so the
// next item is taken while it waits.
// Configuration writes (Q at indexes 0-3, R at 4-7) belong between steps;
// indexes above 7 are ignored.
module kalman_filter_two_state #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_angle_measured,
  input  logic signed [31:0] in_rate_measured,
  input  logic [23:0] in_time_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_angle_estimate,
  output logic signed [31:0] out_rate_estimate,
  output logic signed [31:0] out_angle_predicted,
  output logic signed [31:0] out_rate_predicted,
  output logic signed [31:0] out_cov_out_00,
  output logic signed [31:0] out_cov_out_01,
  output logic signed [31:0] out_cov_out_10,
  output logic signed [31:0] out_cov_out_11,
  output logic        out_singular_flag,
  output logic        out_saturated_flag,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  import kf2_pkg::*;

  localparam logic [31:0] ONE_VAL = 32'(64'd1 << FRAC_BITS);

  seq_state_t       state_r, state_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  uop_t             uop;

  logic [31:0] q00_r, q01_r, q10_r, q11_r, r00_r, r01_r, r10_r, r11_r;
  logic [31:0] est0_r, est1_r, cov0_r, cov1_r, cov2_r, cov3_r;
  logic [31:0] xp0_r, xp1_r, z0_r, z1_r;
  logic [23:0] dt_r;
  logic        sing_r, sat_r;

  logic [31:0] out_est0_r, out_est1_r, out_xp0_r, out_xp1_r;
  logic [31:0] out_cov0_r, out_cov1_r, out_cov2_r, out_cov3_r;
  logic        out_sing_r, out_sat_r, out_valid_r;

  logic [31:0] ram_a, ram_b, opa, opb;
  logic        accept, advance, capture;
  logic        wb_en, sat_set, div_start, div_done, div_sat;
  logic [31:0] wb_data, alu_res, div_q;
  logic        alu_sat;
  alu_ctl_t    alu_ctl;

  assign uop    = uop_rom(pc_r);
  assign accept = in_valid && in_ready;

  // Select a named register operand
  function automatic logic [31:0] flop_val(input logic [SEL_W-1:0] s);
    logic [31:0] v;
    case (s)
      SRC_Q00:  v = q00_r;
      SRC_Q01:  v = q01_r;
      SRC_Q10:  v = q10_r;
      SRC_Q11:  v = q11_r;
      SRC_R00:  v = r00_r;
      SRC_R01:  v = r01_r;
      SRC_R10:  v = r10_r;
      SRC_R11:  v = r11_r;
      SRC_EST0: v = est0_r;
      SRC_EST1: v = est1_r;
      SRC_COV0: v = cov0_r;
      SRC_COV1: v = cov1_r;
      SRC_COV2: v = cov2_r;
      SRC_COV3: v = cov3_r;
      SRC_Z0:   v = z0_r;
      SRC_Z1:   v = z1_r;
      SRC_DT:   v = {8'd0, dt_r};
      SRC_ONE:  v = ONE_VAL;
      SRC_XP0:  v = xp0_r;
      SRC_XP1:  v = xp1_r;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign opa = uop.sa[SEL_W-1] ? ram_a : flop_val(uop.sa);
  assign opb = uop.sb[SEL_W-1] ? ram_b : flop_val(uop.sb);

  kf2_ram #(
    .WIDTH(DATA_W),
    .DEPTH(TMP_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (wb_en && uop.dst[SEL_W-1]),
    .waddr   (uop.dst[TMP_AW-1:0]),
    .wdata   (wb_data),
    .raddr_a (uop.sa[TMP_AW-1:0]),
    .raddr_b (uop.sb[TMP_AW-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  kf2_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk (clk),
    .ctl (alu_ctl),
    .a   (opa),
    .b   (opb),
    .res (alu_res),
    .sat (alu_sat)
  );

  kf2_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (opa),
    .d     (opb),
    .done  (div_done),
    .q     (div_q),
    .sat   (div_sat)
  );

  // Sequencer: next state, writeback and unit control
  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r;
    wb_en = 1'b0;
    wb_data = '0;
    sat_set = 1'b0;
    alu_ctl.op = uop.op;
    alu_ctl.mul_load = 1'b0;
    div_start = 1'b0;
    advance = 1'b0;
    capture = 1'b0;
    case (state_r)
      ST_IDLE: begin
        pc_nxt = '0;
        if (in_valid) state_nxt = ST_FETCH;
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (uop.skip_sing && sing_r) begin
          wb_en = 1'b1;
          advance = 1'b1;
        end else begin
          case (uop.op)
            OP_MUL: begin
              alu_ctl.mul_load = 1'b1;
              state_nxt = ST_MULW;
            end
            OP_DIV: begin
              div_start = 1'b1;
              state_nxt = ST_DIVW;
            end
            default: begin
              wb_en = 1'b1;
              wb_data = alu_res;
              sat_set = alu_sat;
              advance = 1'b1;
            end
          endcase
        end
      end
      ST_MULW: begin
        wb_en = 1'b1;
        wb_data = alu_res;
        sat_set = alu_sat;
        advance = 1'b1;
      end
      ST_DIVW: begin
        if (div_done) begin
          wb_en = 1'b1;
          wb_data = div_q;
          sat_set = div_sat;
          advance = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          capture = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (advance) begin
      if (pc_r == PC_LAST) begin
        state_nxt = ST_DONE;
      end else begin
        pc_nxt = pc_r + 1'b1;
        state_nxt = ST_FETCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q00_r <= Q_DIAG_RST;
      q01_r <= '0;
      q10_r <= '0;
      q11_r <= Q_DIAG_RST;
      r00_r <= R_DIAG_RST;
      r01_r <= '0;
      r10_r <= '0;
      r11_r <= R_DIAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_Q00: q00_r <= cfg_wdata;
        REG_Q01: q01_r <= cfg_wdata;
        REG_Q10: q10_r <= cfg_wdata;
        REG_Q11: q11_r <= cfg_wdata;
        REG_R00: r00_r <= cfg_wdata;
        REG_R01: r01_r <= cfg_wdata;
        REG_R10: r10_r <= cfg_wdata;
        REG_R11: r11_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Filter state, flags and named results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est0_r <= '0;
      est1_r <= '0;
      cov0_r <= '0;
      cov1_r <= '0;
      cov2_r <= '0;
      cov3_r <= '0;
      sing_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      if (accept) begin
        sing_r <= 1'b0;
        sat_r  <= 1'b0;
      end else begin
        if (sat_set) sat_r <= 1'b1;
        if (wb_en && uop.set_sing) sing_r <= (wb_data == '0);
      end
      if (wb_en && !uop.dst[SEL_W-1]) begin
        case (uop.dst)
          SRC_EST0: est0_r <= wb_data;
          SRC_EST1: est1_r <= wb_data;
          SRC_COV0: cov0_r <= wb_data;
          SRC_COV1: cov1_r <= wb_data;
          SRC_COV2: cov2_r <= wb_data;
          SRC_COV3: cov3_r <= wb_data;
          default: ;
        endcase
      end
    end
  end

  // Hold the measurement and the prediction
  always_ff @(posedge clk) begin
    if (accept) begin
      z0_r <= in_angle_measured;
      z1_r <= in_rate_measured;
      dt_r <= in_time_step;
    end
    if (wb_en && uop.dst == SRC_XP0) xp0_r <= wb_data;
    if (wb_en && uop.dst == SRC_XP1) xp1_r <= wb_data;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (capture) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_est0_r <= est0_r;
      out_est1_r <= est1_r;
      out_xp0_r  <= xp0_r;
      out_xp1_r  <= xp1_r;
      out_cov0_r <= cov0_r;
      out_cov1_r <= cov1_r;
      out_cov2_r <= cov2_r;
      out_cov3_r <= cov3_r;
      out_sing_r <= sing_r;
      out_sat_r  <= sat_r;
    end
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_angle_estimate  = out_est0_r;
  assign out_rate_estimate   = out_est1_r;
  assign out_angle_predicted = out_xp0_r;
  assign out_rate_predicted  = out_xp1_r;
  assign out_cov_out_00      = out_cov0_r;
  assign out_cov_out_01      = out_cov1_r;
  assign out_cov_out_10      = out_cov2_r;
  assign out_cov_out_11      = out_cov3_r;
  assign out_singular_flag   = out_sing_r;
  assign out_saturated_flag  = out_sat_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_FETCH)
    else $error("accepted item did not start the program");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH || state_r == ST_EXEC) |-> pc_r <= PC_LAST)
    else $error("program counter beyond last step");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIVW)
    else $error("divider finished outside a divide step");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_DONE) |-> $past(pc_r) == PC_LAST)
    else $error("step finished before the last micro-op");

endmodule

FILE: sim/kalman_filter_two_state_tb.sv
`timescale 1ns / 100ps

module kalman_filter_two_state_tb;
  import kf2_pkg::*;

  localparam int FRAC = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_POS = 2147483647;
  localparam int MAX_NEG = -2147483648;

  typedef int mat2_t [4];

  typedef struct {
    int  val [8];  // angle est, rate est, angle pred, rate pred, cov 00..11
    bit  sing;
    bit  sat;
  } kf_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic signed [31:0] in_angle_measured = '0;
  logic signed [31:0] in_rate_measured = '0;
  logic [23:0] in_time_step = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] out_angle_estimate, out_rate_estimate;
  logic signed [31:0] out_angle_predicted, out_rate_predicted;
  logic signed [31:0] out_cov_out_00, out_cov_out_01, out_cov_out_10, out_cov_out_11;
  logic        out_singular_flag, out_saturated_flag;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  kalman_filter_two_state uut (.*);

  // predictor state
  int  noise_regs [8];
  int  est_state [2];
  int  cov_state [4];
  bit  sat_seen;
  kf_result_t expected_q [$];
  bit  failed = 1'b0;
  bit  no_idle = 1'b0;
  int  idle_cycles = 0;

  initial forever #2 clk = ~clk;

  function automatic int sat32(longint v);
    if (v > longint'(MAX_POS)) begin
      sat_seen = 1'b1;
      return MAX_POS;
    end
    if (v < longint'(MAX_NEG)) begin
      sat_seen = 1'b1;
      return MAX_NEG;
    end
    return int'(v);
  endfunction

  function automatic int fmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> FRAC);
  endfunction

  function automatic int fadd(int a, int b);
    return sat32(longint'(a) + longint'(b));
  endfunction

  function automatic int fsub(int a, int b);
    return sat32(longint'(a) - longint'(b));
  endfunction

  function automatic int fdiv(int a, int d);
    return sat32((longint'(a) <<< FRAC) / longint'(d));
  endfunction

  function automatic mat2_t mmul(mat2_t a, mat2_t b);
    mat2_t c;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        c[i*2+j] = fadd(fmul(a[i*2], b[j]), fmul(a[i*2+1], b[2+j]));
    return c;
  endfunction

  function automatic mat2_t mtr(mat2_t a);
    mat2_t c;
    c = '{a[0], a[2], a[1], a[3]};
    return c;
  endfunction

  // One filter step: predict, gain, estimate and Joseph covariance update
  function automatic kf_result_t filter_step(int ang, int rate, int dt);
    kf_result_t r;
    int one, det;
    int xp [2];
    int xe [2];
    int y [2];
    mat2_t a, pp, s, inv, k, m, t1, t2, rm, cv;
    one = 1 << FRAC;
    sat_seen = 1'b0;
    a = '{one, dt, 0, one};
    cv = cov_state;
    xp[0] = fadd(fmul(a[0], est_state[0]), fmul(a[1], est_state[1]));
    xp[1] = fadd(fmul(a[2], est_state[0]), fmul(a[3], est_state[1]));
    pp = mmul(mmul(a, cv), mtr(a));
    for (int i = 0; i < 4; i++) pp[i] = fadd(pp[i], noise_regs[i]);
    for (int i = 0; i < 4; i++) s[i] = fadd(pp[i], noise_regs[4+i]);
    det = fsub(fmul(s[0], s[3]), fmul(s[1], s[2]));
    r.sing = (det == 0);
    if (r.sing) begin
      k = '{0, 0, 0, 0};
    end else begin
      inv[0] = fdiv(s[3], det);
      inv[1] = fdiv(fsub(0, s[1]), det);
      inv[2] = fdiv(fsub(0, s[2]), det);
      inv[3] = fdiv(s[0], det);
      k = mmul(pp, inv);
    end
    y[0] = fsub(ang, xp[0]);
    y[1] = fsub(rate, xp[1]);
    xe[0] = fadd(xp[0], fadd(fmul(k[0], y[0]), fmul(k[1], y[1])));
    xe[1] = fadd(xp[1], fadd(fmul(k[2], y[0]), fmul(k[3], y[1])));
    m = '{fsub(one, k[0]), fsub(0, k[1]), fsub(0, k[2]), fsub(one, k[3])};
    rm = '{noise_regs[4], noise_regs[5], noise_regs[6], noise_regs[7]};
    t1 = mmul(mmul(m, pp), mtr(m));
    t2 = mmul(mmul(k, rm), mtr(k));
    for (int i = 0; i < 4; i++) cov_state[i] = fadd(t1[i], t2[i]);
    est_state = xe;
    r.val = '{xe[0], xe[1], xp[0], xp[1],
              cov_state[0], cov_state[1], cov_state[2], cov_state[3]};
    r.sat = sat_seen;
    return r;
  endfunction

  // Send one measurement; valid stays high afterward for back-to-back transfers
  task automatic send_meas(int ang, int rate, int dt);
    if (!no_idle && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle_measured <= ang;
    in_rate_measured <= rate;
    in_time_step <= dt[23:0];
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(filter_step(ang, rate, dt & 32'hFFFFFF));
  endtask

  // Drain all results and let the sequencer settle before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(int q00, int q01, int q10, int q11,
                            int r00, int r01, int r10, int r11);
    int vals [8];
    vals = '{q00, q01, q10, q11, r00, r01, r10, r11};
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[3:0];
      cfg_wdata <= vals[i];
      noise_regs[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic write_defaults();
    write_regs(65, 0, 0, 65, 65536, 0, 0, 65536);
  endtask

  // Zero noise keeps P at zero from reset, so every step hits a singular S
  task automatic test_singular();
    write_regs(0, 0, 0, 0, 0, 0, 0, 0);
    repeat (5) send_meas($urandom, $urandom, $urandom_range(0, 65536));
  endtask

  task automatic test_field_extremes();
    write_defaults();
    send_meas(0, 0, 0);
    send_meas(MAX_POS, MAX_POS, 0);
    send_meas(MAX_NEG, MAX_NEG, 24'hFFFFFF);
    send_meas(MAX_POS, MAX_NEG, 24'hFFFFFF);
    send_meas(MAX_NEG, MAX_POS, 1);
    send_meas(-1, -1, 24'h800000);
    send_meas(65536, -65536, 655);
    send_meas(0, 0, 0);
  endtask

  // Register extremes plus writes to unused indexes, which must be ignored
  task automatic test_reg_extremes();
    write_regs(MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
    send_meas(1000, -1000, 655);
    send_meas(MAX_POS, 0, 24'hFFFFFF);
    write_regs(MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
    send_meas(-5, 5, 100);
    send_meas(MAX_NEG, MAX_POS, 0);
    wait_idle();
    for (int i = 8; i < 16; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[3:0];
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    send_meas(12345, -54321, 3000);
  endtask

  task automatic test_random_tracking();
    int ang, rate, dt, sel;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) write_defaults();
      else if (ph == 5)
        write_regs($urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      else
        write_regs($urandom_range(0, 6553), $urandom_range(0, 100), $urandom_range(0, 100),
                   $urandom_range(0, 6553), $urandom_range(1, 1 << 20),
                   $urandom_range(0, 1000), $urandom_range(0, 1000),
                   $urandom_range(1, 1 << 20));
      for (int n = 0; n < 75; n++) begin
        no_idle = (ph == 2);
        sel = $urandom_range(99);
        if (sel < 60) begin
          ang = $signed($urandom_range(0, 11796480)) - 5898240;
          rate = $signed($urandom_range(0, 2000000)) - 1000000;
          dt = $urandom_range(0, 6553);
        end else if (sel < 85) begin
          ang = $urandom;
          rate = $urandom;
          dt = $urandom_range(0, 24'hFFFFFF);
        end else begin
          ang = $signed($urandom_range(0, 200000)) - 100000;
          rate = $signed($urandom_range(0, 200000)) - 100000;
          dt = $urandom_range(0, 655360);
        end
        send_meas(ang, rate, dt);
      end
      no_idle = 1'b0;
    end
  endtask

  // Result side: random stall, compare against the oldest prediction
  always @(posedge clk) begin
    kf_result_t exp_r;
    int got [8];
    string names [8];
    names = '{"angle_estimate", "rate_estimate", "angle_predicted", "rate_predicted",
              "cov_out_00", "cov_out_01", "cov_out_10", "cov_out_11"};
    out_ready <= no_idle || ($urandom_range(99) >= 25);
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        failed = 1'b1;
      end else begin
        exp_r = expected_q.pop_front();
        got = '{out_angle_estimate, out_rate_estimate, out_angle_predicted,
                out_rate_predicted, out_cov_out_00, out_cov_out_01,
                out_cov_out_10, out_cov_out_11};
        for (int i = 0; i < 8; i++)
          if (got[i] != exp_r.val[i]) begin
            $error("%s: expected %0d, got %0d", names[i], exp_r.val[i], got[i]);
            failed = 1'b1;
          end
        if (out_singular_flag !== exp_r.sing) begin
          $error("singular_flag: expected %0d, got %0d", exp_r.sing, out_singular_flag);
          failed = 1'b1;
        end
        if (out_saturated_flag !== exp_r.sat) begin
          $error("saturated_flag: expected %0d, got %0d", exp_r.sat, out_saturated_flag);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    noise_regs = '{65, 0, 0, 65, 65536, 0, 0, 65536};
    est_state = '{0, 0};
    cov_state = '{0, 0, 0, 0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_singular();
    test_field_extremes();
    test_reg_extremes();
    test_random_tracking();
    wait_idle();
    if (!failed)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
